>>> hdl/newton_divided_difference_interpolator_core_defines.svh
// Assertion macros shared by the interpolator checker.
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERPOLATOR_CORE_DEFINES_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERPOLATOR_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define NDD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define NDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/ndd_pkg.sv
// Package: widths, request kinds, status codes and state encodings of the interpolator.
package ndd_pkg;
    localparam int MaxPoints = 16;
    localparam int FracBits  = 16;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int WordW     = 48;
    localparam int QuotBits  = 50 + FracBits;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_EVAL  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NONE = 3'd1;
    localparam logic [2:0] ST_REP  = 3'd2;
    localparam logic [2:0] ST_DROP = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    localparam logic signed [WordW-1:0] Pos48 = {1'b0, {(WordW-1){1'b1}}};
    localparam logic signed [WordW-1:0] Neg48 = {1'b1, {(WordW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LWAIT, S_LDIV, S_LWR, S_LFIN,
        S_ERD, S_EWAIT, S_EMUL, S_EMWAIT, S_EADD, S_EOUT, S_OUT
    } state_t;

    // Start / done link between sequencer and divider
    typedef struct packed {
        logic                    start;
        logic signed [WordW:0]   num;
        logic signed [32:0]      den;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [WordW-1:0] quot;
        logic                    sat;
    } div_rsp_t;
endpackage

>>> hdl/newton_divided_difference_interpolator_core.sv
// Newton divided-difference interpolator top level: stores, sequencer, divider and multiplier.
// One request at a time. A load walks the stored diagonal, one serial division per table
// cell plus memory access. An evaluate walks the coefficients from the top, one multiply
// and a memory read per step. Results sit in an output register; a new request is taken
// once the previous result has been handed over.
module newton_divided_difference_interpolator_core
    import ndd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // point_x[31:0], point_y[63:32], target_x[95:64]
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // value
    output logic [2:0]   m_tuser    // status
);
    // Stores: abscissa, coefficient and diagonal
    logic [31:0]       xmem [MaxPoints];
    logic [WordW-1:0]  cmem [MaxPoints];
    logic [WordW-1:0]  dmem [MaxPoints];
    logic [31:0]       xrd;
    logic [WordW-1:0]  crd, drd;
    logic [AddrW-1:0]  raddr;
    logic [AddrW-1:0]  draddr;
    logic              xwe, cwe, dwe;
    logic [AddrW-1:0]  xwa, cwa, dwa;
    logic [31:0]       xwd;
    logic [WordW-1:0]  cwd, dwd;

    always_ff @(posedge clk)
    begin
        if (xwe) xmem[xwa] <= xwd;
        if (cwe) cmem[cwa] <= cwd;
        if (dwe) dmem[dwa] <= dwd;
        xrd <= xmem[raddr];
        crd <= cmem[raddr];
        drd <= dmem[draddr];
    end

    state_t state_reg, state_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             drop_reg, drop_next, rep_reg, rep_next, sat_reg, sat_next;
    logic [CntW-1:0]  j_reg, j_next;
    logic signed [31:0] px_reg, tx_reg;
    logic signed [WordW-1:0] prev_reg, prev_next, acc_reg, acc_next;
    logic             esat_reg, esat_next;
    logic [31:0]      oval_reg, oval_next;
    logic [2:0]       ost_reg, ost_next;
    logic             ovalid_reg, ovalid_next;
    logic signed [32:0] den;
    logic signed [32:0] tdiff;
    logic signed [WordW:0] dsum;
    logic             mstart;
    logic signed [WordW-1:0] mprod;
    logic             mdone, msat;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic signed [WordW:0] csum;
    logic signed [WordW-1:0] cl;
    logic             clsat;

    ndd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    ndd_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(acc_reg),
                   .b(WordW'(tdiff)), .done(mdone), .prod(mprod), .sat(msat));

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = oval_reg;
    assign m_tuser  = ost_reg;

    always_comb
    begin
        den   = 33'(px_reg) - 33'(signed'(xrd));
        tdiff = 33'(tx_reg) - 33'(signed'(xrd));
        dsum  = (WordW+1)'(prev_reg) - (WordW+1)'(signed'(drd));
        csum  = (WordW+1)'(signed'(crd)) + (WordW+1)'(mprod);
        clsat = 1'b0;
        if (csum > (WordW+1)'(Pos48))
        begin
            cl = Pos48; clsat = 1'b1;
        end
        else if (csum < (WordW+1)'(Neg48))
        begin
            cl = Neg48; clsat = 1'b1;
        end
        else
            cl = WordW'(csum);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tready)
                begin
                    case (s_tuser)
                        KIND_LOAD:
                            state_next = (cnt_reg >= CntW'(MaxPoints)) ? S_IDLE :
                                         (cnt_reg == '0) ? S_LFIN : S_LRD;
                        KIND_EVAL:
                            state_next = (cnt_reg == '0 || rep_reg) ? S_OUT : S_ERD;
                        default: state_next = S_IDLE;
                    endcase
                end
            S_LRD:   state_next = S_LWAIT;
            S_LWAIT: state_next = (den == '0) ? S_LWR : S_LDIV;
            S_LDIV:  state_next = drsp.done ? S_LWR : S_LDIV;
            S_LWR:   state_next = (j_reg == cnt_reg) ? S_LFIN : S_LRD;
            S_LFIN:  state_next = S_IDLE;
            S_ERD:   state_next = S_EWAIT;
            S_EWAIT: state_next = (j_reg == '0) ? S_EOUT : S_EMUL;
            S_EMUL:  state_next = S_EMWAIT;
            S_EMWAIT: state_next = mdone ? S_EADD : S_EMWAIT;
            S_EADD:  state_next = S_ERD;
            S_EOUT:  state_next = S_IDLE;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next = cnt_reg; drop_next = drop_reg; rep_next = rep_reg; sat_next = sat_reg;
        j_next = j_reg; prev_next = prev_reg; acc_next = acc_reg;
        esat_next = esat_reg; oval_next = oval_reg; ost_next = ost_reg;
        ovalid_next = ovalid_reg && !m_tready;
        raddr = '0; xwe = 1'b0; cwe = 1'b0; dwe = 1'b0;
        // diag[j-1] is the only diagonal cell a load step needs
        draddr = AddrW'(j_reg - 1'b1);
        xwa = '0; cwa = '0; dwa = '0; xwd = px_reg; cwd = prev_reg; dwd = prev_reg;
        dreq.start = 1'b0; dreq.num = dsum; dreq.den = den;
        mstart = 1'b0;
        case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tready)
                begin
                    case (s_tuser)
                        KIND_LOAD:
                        begin
                            if (cnt_reg >= CntW'(MaxPoints)) drop_next = 1'b1;
                            prev_next = WordW'(signed'(s_tdata[63:32]));
                            j_next    = CntW'(1);
                        end
                        KIND_EVAL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                oval_next = '0; ost_next = ST_NONE; ovalid_next = 1'b1;
                            end
                            else if (rep_reg)
                            begin
                                oval_next = '0; ost_next = ST_REP; ovalid_next = 1'b1;
                            end
                            j_next    = cnt_reg - 1'b1;
                            esat_next = sat_reg;
                        end
                        KIND_CLEAR:
                        begin
                            cnt_next = '0; drop_next = 1'b0; rep_next = 1'b0; sat_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            // Read x[n-j] and diag[j-1]; x[n-j] is held until the cell is written
            S_LRD: raddr = AddrW'(cnt_reg - j_reg);
            S_LWAIT:
            begin
                raddr = AddrW'(cnt_reg - j_reg);
                dreq.start = (den != '0);
                if (den == '0) rep_next = 1'b1;
            end
            S_LDIV: raddr = AddrW'(cnt_reg - j_reg);
            S_LWR:
            begin
                // write old cell j-1 (prev), carry new cell j
                dwe = 1'b1; dwa = AddrW'(j_reg - 1'b1); dwd = prev_reg;
                if (den == '0) prev_next = '0;
                else
                begin
                    prev_next = drsp.quot;
                    if (drsp.sat) sat_next = 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            S_LFIN:
            begin
                dwe = 1'b1; dwa = AddrW'(cnt_reg); dwd = prev_reg;
                cwe = 1'b1; cwa = AddrW'(cnt_reg); cwd = prev_reg;
                xwe = 1'b1; xwa = AddrW'(cnt_reg); xwd = px_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            S_ERD: raddr = AddrW'(j_reg);
            S_EWAIT:
            begin
                raddr = AddrW'(j_reg - 1'b1);
                if (j_reg == cnt_reg - 1'b1) acc_next = crd;
            end
            S_EMUL:
            begin
                raddr = AddrW'(j_reg - 1'b1);
                mstart = 1'b1;
            end
            S_EMWAIT: raddr = AddrW'(j_reg - 1'b1);
            S_EADD:
            begin
                if (msat || clsat) esat_next = 1'b1;
                acc_next = cl;
                j_next = j_reg - 1'b1;
            end
            S_EOUT:
            begin
                ovalid_next = 1'b1;
                if (acc_reg > 48'sd2147483647)
                begin
                    oval_next = 32'h7FFF_FFFF; ost_next = ST_SAT;
                end
                else if (acc_reg < -48'sd2147483648)
                begin
                    oval_next = 32'h8000_0000; ost_next = ST_SAT;
                end
                else
                begin
                    oval_next = acc_reg[31:0];
                    ost_next = esat_reg ? ST_SAT : (drop_reg ? ST_DROP : ST_OK);
                end
            end
            default: ;
        endcase
    end

    // The divider sees diag via prev - drd at the read of S_LWAIT; hold operands
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid && s_tready)
        begin
            px_reg <= s_tdata[31:0];
            tx_reg <= s_tdata[95:64];
        end
        j_reg    <= j_next;
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        esat_reg <= esat_next;
        oval_reg <= oval_next;
        ost_reg  <= ost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
            rep_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
            rep_reg    <= rep_next;
            sat_reg    <= sat_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

>>> hdl/ndd_div.sv
// Restoring bit-serial divider: (num << FracBits) / den, truncated, saturated to 48 bits.
module ndd_div
    import ndd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int IdxW = $clog2(QuotBits + 1);
    localparam logic [49:0] Lim = 50'd1 << 48;
    localparam logic [49:0] NegLim = 50'd1 << 47;

    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic [49:0]      n_reg, n_next;
    logic [33:0]      d_reg, d_next;
    logic [34:0]      r_reg, r_next;
    logic [49:0]      q_reg, q_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic [34:0]      r_sh;
    logic [49:0]      q_sh;
    logic             nbit;
    logic [IdxW-1:0]  fi;

    // One quotient bit per cycle
    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        fi        = IdxW'(FracBits);
        nbit      = (idx_reg >= fi) ? n_reg[6'(idx_reg - fi)] : 1'b0;
        r_sh      = {r_reg[33:0], nbit};
        q_sh      = {q_reg[48:0], 1'b0};
        if (req.start)
        begin
            busy_next = 1'b1;
            idx_next  = IdxW'(QuotBits - 1);
            n_next    = req.num[WordW] ? 50'(-req.num) : 50'(req.num);
            d_next    = req.den[32] ? 34'(-req.den) : 34'(req.den);
            neg_next  = req.num[WordW] ^ req.den[32];
            r_next    = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_sh   = q_sh | 50'd1;
            end
            else
                r_next = r_sh;
            q_next = (q_sh > Lim) ? Lim : q_sh;
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    // Sign and saturation
    always_comb
    begin
        rsp.done = done_reg;
        rsp.sat  = 1'b0;
        if (neg_reg)
        begin
            if (q_reg > NegLim)
            begin
                rsp.sat  = 1'b1;
                rsp.quot = Neg48;
            end
            else
                rsp.quot = WordW'(-q_reg);
        end
        else if (q_reg > 50'(Pos48))
        begin
            rsp.sat  = 1'b1;
            rsp.quot = Pos48;
        end
        else
            rsp.quot = WordW'(q_reg);
    end
endmodule

>>> hdl/ndd_mul.sv
// Multi-cycle fixed-point multiplier: 48x48 via 24x24 partial products, rounded, saturated.
module ndd_mul
    import ndd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [WordW-1:0] a,
    input  logic signed [WordW-1:0] b,
    output logic                    done,
    output logic signed [WordW-1:0] prod,
    output logic                    sat
);
    logic [47:0] x_reg, y_reg;
    logic        neg_reg;
    logic [2:0]  ph_reg;
    logic        busy_reg, done_reg;
    logic [95:0] acc_reg;
    logic [47:0] pp_reg;
    logic [23:0] xa, yb;
    logic [96:0] rnd;
    logic [48:0] m;
    logic [6:0]  sh;

    // Four partial products, one per cycle, then accumulated
    always_comb
    begin
        case (ph_reg[1:0])
            2'd0:    begin xa = x_reg[23:0];  yb = y_reg[23:0];  sh = 7'd0;  end
            2'd1:    begin xa = x_reg[47:24]; yb = y_reg[23:0];  sh = 7'd24; end
            2'd2:    begin xa = x_reg[23:0];  yb = y_reg[47:24]; sh = 7'd24; end
            default: begin xa = x_reg[47:24]; yb = y_reg[47:24]; sh = 7'd48; end
        endcase
    end

    logic [6:0] sh_reg;
    logic       pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pv_reg   <= 1'b0;
            ph_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                pv_reg <= (ph_reg < 3'd4);
                if (ph_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    ph_reg <= ph_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= a[WordW-1] ? 48'(-a) : 48'(a);
            y_reg   <= b[WordW-1] ? 48'(-b) : 48'(b);
            neg_reg <= a[WordW-1] ^ b[WordW-1];
            acc_reg <= '0;
        end
        else
        begin
            pp_reg <= xa * yb;
            sh_reg <= sh;
            if (pv_reg)
                acc_reg <= acc_reg + (96'(pp_reg) << sh_reg);
        end
    end

    // Round half away (on magnitude), shift, saturate
    always_comb
    begin
        rnd  = 97'(acc_reg) + (97'd1 << (FracBits - 1));
        m    = (rnd[96:FracBits+48] != '0) ? (49'd1 << 48) : rnd[FracBits+48:FracBits];
        done = done_reg;
        sat  = 1'b0;
        if (neg_reg)
        begin
            if (m > (49'd1 << 47))
            begin
                sat  = 1'b1;
                prod = Neg48;
            end
            else
                prod = WordW'(-m);
        end
        else if (m > 49'(Pos48))
        begin
            sat  = 1'b1;
            prod = Pos48;
        end
        else
            prod = WordW'(m);
    end
endmodule

>>> hdl/ndd_checker.sv
// Port-level checker for the interpolator, bound to the top level.
`include "newton_divided_difference_interpolator_core_defines.svh"
module ndd_checker
    import ndd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser
);
    // Only evaluate requests produce results, one at a time
    `NDD_ASSERT_IMPL(a_busy_out, clk, rst_n, m_tvalid, !s_tready, "request taken with result pending")
    `NDD_ASSERT_IMPL(a_status_range, clk, rst_n, m_tvalid, m_tuser <= ST_SAT, "bad status code")
    `NDD_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser), "stalled result changed")
    `NDD_ASSERT_NEXT(a_clear_quiet, clk, rst_n, s_tvalid && s_tready && s_tuser == KIND_CLEAR, !m_tvalid, "clear produced a result")
endmodule

bind newton_divided_difference_interpolator_core ndd_checker u_ndd_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser)
);

>>> tb/tb_top.sv
// Self-checking testbench for the Newton divided-difference interpolator core.
`timescale 1ns / 100ps

module tb_top;
    import ndd_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] tx;
    } request_t;

    localparam int RandItems = 850;
    localparam int DrainCycles = 1200;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // point_x[31:0], point_y[63:32], target_x[95:64]
    logic [1:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // value
    logic [2:0]  m_tuser;   // status

    request_t    pending_q[$];
    logic [31:0] value_q[$];
    logic [2:0]  status_q[$];
    int          total_reqs;
    int          sent_cnt;
    int          accepted_cnt;
    int          eval_cnt;
    int          result_cnt;
    int          error_cnt;
    int          phase;
    int          hold_left;
    bit          hold_done;
    bit          took_req;

    // Interpolator model state
    longint      abscissa[MaxPoints];
    longint      coeff[MaxPoints];
    longint      diag[MaxPoints];
    int          npoints;
    bit          dropped;
    bit          repeated;
    bit          saturated;

    newton_divided_difference_interpolator_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Fixed-point helpers, 48-bit saturating
    function automatic logic [63:0] magnitude(longint v);
        return 64'(v < 0 ? -v : v);
    endfunction

    function automatic longint sat48(bit neg, logic [63:0] mag, inout bit s);
        if (neg)
        begin
            if (mag > (64'd1 << 47))
            begin
                s = 1'b1;
                return longint'(Neg48);
            end
            return -longint'(mag);
        end
        if (mag > 64'(Pos48))
        begin
            s = 1'b1;
            return longint'(Pos48);
        end
        return longint'(mag);
    endfunction

    function automatic longint clamp48(longint v, inout bit s);
        if (v > longint'(Pos48))
        begin
            s = 1'b1;
            return longint'(Pos48);
        end
        if (v < longint'(Neg48))
        begin
            s = 1'b1;
            return longint'(Neg48);
        end
        return v;
    endfunction

    // Serial quotient, truncated toward zero, clipped at 2^48
    function automatic longint div_fix(longint num, longint den, inout bit s);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] q;
        logic        b;
        n = magnitude(num);
        d = magnitude(den);
        r = '0;
        q = '0;
        for (int i = 49 + FracBits; i >= 0; i--)
        begin
            b = (i >= FracBits) ? n[i - FracBits] : 1'b0;
            r = {r[62:0], b};
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q[0] = 1'b1;
            end
            if (q > (64'd1 << 48))
                q = 64'd1 << 48;
        end
        return sat48((num < 0) != (den < 0), q, s);
    endfunction

    // Product rounded to nearest, ties away from zero
    function automatic longint mul_fix(longint a, longint b, inout bit s);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)} + (128'd1 << (FracBits - 1));
        if (p[127:FracBits+64] != '0)
            m = 64'd1 << 48;
        else
            m = p[FracBits+63:FracBits];
        return sat48((a < 0) != (b < 0), m, s);
    endfunction

    // Update the model for one accepted request, queue any expected result
    task automatic interpolate(logic [1:0] kind, logic [95:0] data);
        longint nd[MaxPoints];
        longint x;
        longint den;
        longint t;
        longint acc;
        longint p;
        bit     s;
        x = longint'(signed'(data[31:0]));
        case (kind)
            KIND_LOAD:
            begin
                if (npoints >= MaxPoints)
                    dropped = 1'b1;
                else
                begin
                    nd[0] = longint'(signed'(data[63:32]));
                    for (int j = 1; j <= npoints; j++)
                    begin
                        den = x - abscissa[npoints - j];
                        if (den == 0)
                        begin
                            repeated = 1'b1;
                            nd[j] = 0;
                        end
                        else
                            nd[j] = div_fix(nd[j - 1] - diag[j - 1], den, saturated);
                    end
                    for (int j = 0; j <= npoints; j++)
                        diag[j] = nd[j];
                    abscissa[npoints] = x;
                    coeff[npoints] = nd[npoints];
                    npoints++;
                end
            end
            KIND_CLEAR:
            begin
                npoints = 0;
                dropped = 1'b0;
                repeated = 1'b0;
                saturated = 1'b0;
            end
            KIND_EVAL:
            begin
                eval_cnt++;
                if (npoints == 0)
                begin
                    value_q.push_back('0);
                    status_q.push_back(ST_NONE);
                end
                else if (repeated)
                begin
                    value_q.push_back('0);
                    status_q.push_back(ST_REP);
                end
                else
                begin
                    // Horner walk from the top coefficient down
                    t = longint'(signed'(data[95:64]));
                    s = saturated;
                    acc = coeff[npoints - 1];
                    for (int k = npoints - 1; k > 0; k--)
                    begin
                        p = mul_fix(acc, t - abscissa[k - 1], s);
                        acc = clamp48(coeff[k - 1] + p, s);
                    end
                    if (acc > 64'sd2147483647)
                    begin
                        acc = 64'sd2147483647;
                        s = 1'b1;
                    end
                    if (acc < -64'sd2147483648)
                    begin
                        acc = -64'sd2147483648;
                        s = 1'b1;
                    end
                    value_q.push_back(acc[31:0]);
                    status_q.push_back(s ? ST_SAT : (dropped ? ST_DROP : ST_OK));
                end
            end
            default: ;
        endcase
    endtask

    // Monitor: accept requests into the model, check results
    always @(posedge clk)
    begin
        took_req = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            took_req = 1'b1;
            accepted_cnt++;
            interpolate(s_tuser, s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            result_cnt++;
            if (value_q.size() == 0)
            begin
                $error("unexpected result: value %h status %0d", m_tdata, m_tuser);
                error_cnt++;
            end
            else
            begin
                if (m_tdata !== value_q[0])
                begin
                    $error("value: expected %h, actual %h", value_q[0], m_tdata);
                    error_cnt++;
                end
                if (m_tuser !== status_q[0])
                begin
                    $error("status: expected %0d, actual %0d", status_q[0], m_tuser);
                    error_cnt++;
                end
                void'(value_q.pop_front());
                void'(status_q.pop_front());
            end
        end
    end

    // Long output hold-off once the receiver-stall phase begins
    always @(posedge clk)
    begin
        if (!hold_done && phase == 2)
        begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Request driver
    always @(negedge clk)
    begin
        request_t r;
        int       idle_pct;
        phase = (total_reqs == 0) ? 0 : (sent_cnt * 4) / total_reqs;
        idle_pct = (phase == 1) ? 73 : ((phase == 3) ? 21 : 0);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || took_req)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                r = pending_q.pop_front();
                sent_cnt++;
                s_tvalid <= 1'b1;
                s_tuser  <= r.kind;
                s_tdata  <= {r.tx, r.py, r.px};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver
    always @(negedge clk)
    begin
        int stall_pct;
        stall_pct = (phase == 2) ? 73 : ((phase == 3) ? 21 : 0);
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    task automatic add_req(logic [1:0] kind, logic [31:0] px, logic [31:0] py,
                           logic [31:0] tx);
        request_t r;
        r.kind = kind;
        r.px = px;
        r.py = py;
        r.tx = tx;
        pending_q.push_back(r);
    endtask

    // Stimulus and end of run
    initial
    begin
        int          npts;
        int          stride;
        int          base;
        int          full;
        logic [31:0] xs[$];
        logic [31:0] x;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_CLEAR;
        m_tready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        npoints = 0;
        dropped = 1'b0;
        repeated = 1'b0;
        saturated = 1'b0;
        total_reqs = 0;

        // Directed: empty store, field extremes, repeated x, ignored kind, saturation
        add_req(KIND_EVAL, 32'h0, 32'h0, 32'h0);
        add_req(KIND_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        add_req(KIND_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        add_req(KIND_EVAL, 32'h0, 32'h0, 32'h0);
        add_req(KIND_EVAL, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
        add_req(KIND_EVAL, 32'h0, 32'h0, 32'h7fff_ffff);
        add_req(KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_req(KIND_LOAD, 32'h0001_0000, 32'h0001_0000, 32'h0);
        add_req(KIND_LOAD, 32'h0001_0000, 32'h0002_0000, 32'h0);
        add_req(KIND_EVAL, 32'h0, 32'h0, 32'h0001_8000);
        add_req(2'd3, 32'h1234_5678, 32'h9abc_def0, 32'h0);
        add_req(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
        add_req(KIND_LOAD, 32'h0, 32'h7fff_ffff, 32'h0);
        add_req(KIND_LOAD, 32'h0000_0001, 32'h8000_0000, 32'h0);
        add_req(KIND_LOAD, 32'h0000_0002, 32'h7fff_ffff, 32'h0);
        add_req(KIND_EVAL, 32'h0, 32'h0, 32'h7fff_ffff);
        add_req(KIND_EVAL, 32'h0, 32'h0, 32'h0000_0001);
        add_req(KIND_CLEAR, 32'h0, 32'h0, 32'h0);

        // Random: mostly clear, load a set, evaluate it; some noise
        while (pending_q.size() < RandItems + 18)
        begin
            if ($urandom_range(9) != 0)
                add_req(KIND_CLEAR, $urandom, $urandom, $urandom);
            npts = ($urandom_range(9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 6);
            full = ($urandom_range(4) == 0);
            stride = 1 << $urandom_range(12, 20);
            base = $signed($urandom) >>> 6;
            xs.delete();
            for (int i = 0; i < npts; i++)
            begin
                if (full)
                    x = $urandom;
                else
                    x = base + i * stride + $urandom_range(0, stride / 2);
                if (i > 0 && $urandom_range(19) == 0)
                    x = xs[$urandom_range(xs.size() - 1)];
                xs.push_back(x);
                add_req(KIND_LOAD, x,
                        full ? $urandom : 32'($signed($urandom) >>> 11), $urandom);
            end
            repeat ($urandom_range(1, 3))
                add_req(KIND_EVAL, $urandom, $urandom,
                        full || $urandom_range(3) == 0 ? $urandom
                                : base + $urandom_range(0, npts * stride));
            if ($urandom_range(7) == 0)
                add_req($urandom_range(2) == 0 ? 2'd3 : 2'($urandom), $urandom, $urandom,
                        $urandom);
        end
        total_reqs = pending_q.size();

        wait (rst_n);
        wait (pending_q.size() == 0 && !s_tvalid);
        wait (value_q.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        if (value_q.size() != 0)
        begin
            $error("%0d results never arrived", value_q.size());
            error_cnt++;
        end
        $display("%0d requests taken (%0d evaluations), %0d results checked",
                 accepted_cnt, eval_cnt, result_cnt);
        $display("covered point sets up to overflow, repeated x, saturation and stalls");
        if (error_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
